@@ design/rmq_pkg.sv @@
// shared constants for the rotation matrix to quaternion block
`default_nettype none
package rmq_pkg;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;

    // signed width of the radicand 1 + a - b - c
    function automatic int rad_width(input int w, input int f);
        return ((f + 1 > w) ? f + 1 : w) + 2;
    endfunction
endpackage
`default_nettype wire

@@ design/rmq_if.sv @@
// handshake channels for matrices in and quaternions out
`default_nettype none
interface rmq_in_if #(parameter int DATA_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
    modport source (output valid, e11, e12, e13, e21, e22, e23, e31, e32, e33,
                    input ready);
    modport sink (input valid, e11, e12, e13, e21, e22, e23, e31, e32, e33,
                  output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz;
    logic degenerate;
    modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
    modport sink (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface
`default_nettype wire

@@ design/rotation_matrix_to_quaternion_top.sv @@
// top level: rotation matrix to unit quaternion
// throughput: one matrix per cycle, back to back, while the output side does not stall
// pipeline: front register, queue, then 1 + R root stages, 1 + D divide stages and the output
//   register, R = (T + FRAC_BITS + 1) / 2, D = DATA_WIDTH + FRAC_BITS + 2,
//   T = max(DATA_WIDTH, FRAC_BITS + 1) + 2
// synchronous active-low reset clears all valid flags and queue pointers
`default_nettype none
module rotation_matrix_to_quaternion_top #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmq_in_if.sink      i_item,
    rmq_out_if.source   o_item
);
    import rmq_pkg::*;
    localparam int TW = rad_width(DATA_WIDTH, FRAC_BITS);
    localparam int FW = 2 + 1 + TW + 3 + 3 * (DATA_WIDTH + 1);

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [FW-1:0] f_data, b_data;

    rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .FW(FW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item),
        .o_valid(f_valid), .i_ready(f_ready), .o_data(f_data)
    );

    rmq_queue #(.FW(FW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_data),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(b_data)
    );

    rmq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .FW(FW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_data(b_data),
        .o_item(o_item)
    );
endmodule
`default_nettype wire

@@ design/rmq_front.sv @@
// front stage: picks e11 or e22 if strictly largest, else e33; forms radicand and numerators
`default_nettype none
module rmq_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int FW         = 100
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rmq_in_if.sink             i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [FW-1:0]      o_data
);
    import rmq_pkg::*;
    localparam int W  = DATA_WIDTH;
    localparam int TW = rad_width(DATA_WIDTH, FRAC_BITS);
    localparam int NW = W + 1;

    logic               r_vld;
    logic [FW-1:0]      r_data;
    logic [FW-1:0]      n_data;
    logic signed [TW-1:0] a, b, c, p, o1, o2, t;
    logic signed [NW-1:0] n0, n1, n2;
    logic [NW-1:0]      m0, m1, m2;
    logic [1:0]         sel;

    function automatic logic signed [NW-1:0] ext(input logic signed [W-1:0] v);
        return NW'(v);
    endfunction

    always_comb begin
        a = TW'(i_item.e11);
        b = TW'(i_item.e22);
        c = TW'(i_item.e33);
        if (a > b && a > c) begin
            sel = SEL_X; p = a; o1 = b; o2 = c;
            n0 = ext(i_item.e32) - ext(i_item.e23);
            n1 = ext(i_item.e12) + ext(i_item.e21);
            n2 = ext(i_item.e31) + ext(i_item.e13);
        end else if (b > a && b > c) begin
            sel = SEL_Y; p = b; o1 = a; o2 = c;
            n0 = ext(i_item.e13) - ext(i_item.e31);
            n1 = ext(i_item.e12) + ext(i_item.e21);
            n2 = ext(i_item.e23) + ext(i_item.e32);
        end else begin
            sel = SEL_Z; p = c; o1 = a; o2 = b;
            n0 = ext(i_item.e21) - ext(i_item.e12);
            n1 = ext(i_item.e31) + ext(i_item.e13);
            n2 = ext(i_item.e23) + ext(i_item.e32);
        end
        t  = (TW'(1) <<< FRAC_BITS) + p - o1 - o2;
        m0 = n0[NW-1] ? NW'(-n0) : NW'(n0);
        m1 = n1[NW-1] ? NW'(-n1) : NW'(n1);
        m2 = n2[NW-1] ? NW'(-n2) : NW'(n2);
        n_data = {sel, (t <= 0), t, n0[NW-1], n1[NW-1], n2[NW-1], m0, m1, m2};
    end

    assign i_item.ready = !r_vld || i_ready;
    assign o_valid      = r_vld;
    assign o_data       = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_vld <= i_item.valid;
        end
        if (i_item.ready && i_item.valid) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

@@ design/rmq_queue.sv @@
// short queue between front and back
`default_nettype none
module rmq_queue #(
    parameter int FW    = 100,
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [FW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [FW-1:0]      o_data
);
    import rmq_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FW-1:0] r_mem [0:DEPTH-1];
    logic [AW:0]   r_wp, r_rp;
    logic          push, pop, full, empty;

    assign empty   = (r_wp == r_rp);
    assign full    = (r_wp[AW-1:0] == r_rp[AW-1:0]) && (r_wp[AW] != r_rp[AW]);
    assign o_ready = !full;
    assign o_valid = !empty;
    assign o_data  = r_mem[r_rp[AW-1:0]];
    assign push    = i_valid && !full;
    assign pop     = i_ready && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ design/rmq_back.sv @@
// back end: pipelined square root, three pipelined dividers, saturation
`default_nettype none
module rmq_back #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int FW         = 100
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [FW-1:0] i_data,
    rmq_out_if.source          o_item
);
    import rmq_pkg::*;
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int TW = rad_width(DATA_WIDTH, FRAC_BITS);
    localparam int NW = W + 1;
    localparam int RW = TW + F;
    localparam int RB = (RW + 1) / 2;
    localparam int DW = NW + F + 1;
    localparam logic [DW-1:0] LIM_P = DW'((64'(1) << (W - 1)) - 64'(1));
    localparam logic [DW-1:0] LIM_N = DW'(64'(1) << (W - 1));
    localparam logic [W-1:0]  QMAX  = W'((64'(1) << (W - 1)) - 64'(1));
    localparam logic [W-1:0]  QMIN  = W'(64'(1) << (W - 1));
    localparam logic [W-1:0]  QONE  = (F > W - 2) ? QMAX : W'(64'(1) << F);

    logic en;

    // square root stages
    logic [RB:0]            r_sv;
    logic [RW:0]            r_srem [0:RB];
    logic [RB-1:0]          r_sq   [0:RB];
    logic [1:0]             r_ssel [0:RB];
    logic [RB:0]            r_sdeg;
    logic [2:0]             r_sneg [0:RB];
    logic [2:0][NW-1:0]     r_smag [0:RB];

    // divider stages
    logic [DW:0]            r_dv;
    logic [1:0]             r_dsel [0:DW];
    logic [DW:0]            r_ddeg;
    logic [2:0]             r_dneg [0:DW];
    logic [RB-1:0]          r_dr   [0:DW];
    logic [2:0][DW-1:0]     r_dd   [0:DW];
    logic [2:0][RB:0]       r_dpr  [0:DW];
    logic [2:0][DW-1:0]     r_dq   [0:DW];

    logic                   r_ovld;
    logic [W-1:0]           r_qw, r_qx, r_qy, r_qz;
    logic                   r_deg;

    logic [1:0]             in_sel;
    logic                   in_deg;
    logic [TW-1:0]          in_t;
    logic [2:0]             in_neg;
    logic [2:0][NW-1:0]     in_mag;

    assign {in_sel, in_deg, in_t, in_neg, in_mag} = i_data;
    assign en      = !r_ovld || o_item.ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_valid;
        end
        if (en) begin
            r_srem[0] <= {1'b0, in_t, {F{1'b0}}};
            r_sq[0]   <= '0;
            r_ssel[0] <= in_sel;
            r_sdeg[0] <= in_deg;
            r_sneg[0] <= in_neg;
            r_smag[0] <= in_mag;
        end
    end

    for (genvar i = 0; i < RB; i++) begin : g_sqrt
        localparam int B = RB - 1 - i;
        logic [RW:0]   trial;
        logic          take;
        assign trial = (RW+1)'({{(RW+1-RB){1'b0}}, r_sq[i]} << (B + 1))
                     | ((RW+1)'(1) << (2 * B));
        assign take  = r_srem[i] >= trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else if (en) begin
                r_sv[i+1] <= r_sv[i];
            end
            if (en) begin
                r_srem[i+1] <= take ? r_srem[i] - trial : r_srem[i];
                r_sq[i+1]   <= take ? r_sq[i] | (RB'(1) << B) : r_sq[i];
                r_ssel[i+1] <= r_ssel[i];
                r_sdeg[i+1] <= r_sdeg[i];
                r_sneg[i+1] <= r_sneg[i];
                r_smag[i+1] <= r_smag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[RB];
        end
        if (en) begin
            r_dsel[0] <= r_ssel[RB];
            r_ddeg[0] <= r_sdeg[RB];
            r_dneg[0] <= r_sneg[RB];
            r_dr[0]   <= r_sq[RB];
            for (int k = 0; k < 3; k++) begin
                r_dd[0][k]  <= DW'({r_smag[RB][k], {F{1'b0}}}) + DW'(r_sq[RB]);
                r_dpr[0][k] <= '0;
                r_dq[0][k]  <= '0;
            end
        end
    end

    for (genvar j = 0; j < DW; j++) begin : g_div
        localparam int B = DW - 1 - j;
        logic [RB+1:0] sh [0:2];
        logic [RB+1:0] dv;
        logic [2:0]    ge;
        always_comb begin
            dv = {1'b0, r_dr[j], 1'b0};
            for (int k = 0; k < 3; k++) begin
                sh[k] = {r_dpr[j][k], r_dd[j][k][B]};
                ge[k] = sh[k] >= dv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (en) begin
                r_dv[j+1] <= r_dv[j];
            end
            if (en) begin
                r_dsel[j+1] <= r_dsel[j];
                r_ddeg[j+1] <= r_ddeg[j];
                r_dneg[j+1] <= r_dneg[j];
                r_dr[j+1]   <= r_dr[j];
                r_dd[j+1]   <= r_dd[j];
                for (int k = 0; k < 3; k++) begin
                    r_dpr[j+1][k] <= ge[k] ? (RB+1)'(sh[k] - dv) : (RB+1)'(sh[k]);
                    r_dq[j+1][k]  <= {r_dq[j][k][DW-2:0], ge[k]};
                end
            end
        end
    end

    function automatic logic [W-1:0] sat_q(input logic [DW-1:0] q, input logic neg);
        logic [W-1:0] res;
        if (neg) begin
            res = (q > LIM_N) ? QMIN : W'(-q);
        end else begin
            res = (q > LIM_P) ? QMAX : W'(q);
        end
        return res;
    endfunction

    logic [RB:0]   half;
    logic [W-1:0]  pick, s0, s1, s2;
    logic [W-1:0]  n_qw, n_qx, n_qy, n_qz;

    always_comb begin
        half = ((RB+1)'(r_dr[DW]) + (RB+1)'(1)) >> 1;
        pick = (DW'(half) > LIM_P) ? QMAX : W'(half);
        s0   = sat_q(r_dq[DW][2], r_dneg[DW][2]);
        s1   = sat_q(r_dq[DW][1], r_dneg[DW][1]);
        s2   = sat_q(r_dq[DW][0], r_dneg[DW][0]);
        n_qw = s0;
        case (r_dsel[DW])
            SEL_X: begin
                n_qx = pick; n_qy = s1; n_qz = s2;
            end
            SEL_Y: begin
                n_qx = s1; n_qy = pick; n_qz = s2;
            end
            default: begin
                n_qx = s1; n_qy = s2; n_qz = pick;
            end
        endcase
        if (r_ddeg[DW]) begin
            n_qw = QONE; n_qx = '0; n_qy = '0; n_qz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_dv[DW];
        end
        if (en) begin
            r_qw  <= n_qw;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_qz  <= n_qz;
            r_deg <= r_ddeg[DW];
        end
    end

    assign o_item.valid      = r_ovld;
    assign o_item.qw         = r_qw;
    assign o_item.qx         = r_qx;
    assign o_item.qy         = r_qy;
    assign o_item.qz         = r_qz;
    assign o_item.degenerate = r_deg;
endmodule
`default_nettype wire
